// File: sv/pwsh_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package pwsh_pkg;

  localparam int SAMPLE_BITS = 24;
  localparam int DATA_W = ((SAMPLE_BITS + 7) / 8) * 8;

  localparam int CFG_W = 17;
  localparam int IDX_W = 3;

  localparam logic [IDX_W-1:0] REG_KNOB = 3'd0;
  localparam logic [IDX_W-1:0] REG_WET  = 3'd1;
  localparam logic [IDX_W-1:0] REG_LOW  = 3'd2;
  localparam logic [IDX_W-1:0] REG_MID  = 3'd3;
  localparam logic [IDX_W-1:0] REG_HIGH = 3'd4;

  localparam int LOG_ROUNDS = 32;
  localparam int TERMS = 13;

  localparam logic [31:0] LN2_Q32 = 32'd2977044472;
  localparam logic [31:0] ONE_Q31 = 32'h8000_0000;

  // floor(2^32 / n) for the Horner divisors 1..13
  localparam logic [32:0] RECIP [0:15] = '{
    33'd0,
    33'd4294967296, 33'd2147483648, 33'd1431655765, 33'd1073741824,
    33'd858993459,  33'd715827882,  33'd613566756,  33'd536870912,
    33'd477218588,  33'd429496729,  33'd390451572,  33'd357913941,
    33'd330382099,
    33'd0, 33'd0
  };

  // Per-sample data that rides along the pipe
  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] x;
    logic                          neg;
    logic                          zero;
    logic [4:0]                    k;
    logic [10:0]                   shift;
  } side_t;

  function automatic logic [4:0] msb_index(input logic [SAMPLE_BITS-1:0] v);
    logic [4:0] idx;
    idx = 5'd0;
    for (int i = 0; i < SAMPLE_BITS; i++) begin
      if (v[i]) idx = 5'(i);
    end
    return idx;
  endfunction

endpackage
`default_nettype wire

// File: sv/pwsh_log_step.sv
`timescale 1ns / 1ps
`default_nettype none
module pwsh_log_step (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              en,
  input  wire logic              in_valid,
  input  wire pwsh_pkg::side_t   in_side,
  input  wire logic [31:0]       in_z,
  input  wire logic [31:0]       in_f,
  output logic                   out_valid,
  output pwsh_pkg::side_t        out_side,
  output logic [31:0]            out_z,
  output logic [31:0]            out_f
);
  import pwsh_pkg::*;

  logic [63:0] zz;
  logic        bit_out;

  // Square the mantissa; an overflow past 2.0 yields one log bit
  assign zz      = in_z * in_z;
  assign bit_out = zz[63];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_side <= in_side;
      out_z    <= bit_out ? zz[63:32] : zz[62:31];
      out_f    <= {in_f[30:0], bit_out};
    end
  end

endmodule
`default_nettype wire

// File: sv/pwsh_exp_step.sv
`timescale 1ns / 1ps
`default_nettype none
module pwsh_exp_step (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              en,
  input  wire logic [3:0]        term,
  input  wire logic              in_valid,
  input  wire pwsh_pkg::side_t   in_side,
  input  wire logic [31:0]       in_r,
  input  wire logic [30:0]       in_y,
  output logic                   out_valid,
  output pwsh_pkg::side_t        out_side,
  output logic [31:0]            out_r,
  output logic [30:0]            out_y
);
  import pwsh_pkg::*;

  logic        va, vb;
  side_t       sa, sb;
  logic [30:0] ya, yb;
  logic [31:0] qa, qb, estb;

  logic [62:0] prod_ry;
  logic [64:0] prod_rc;
  logic [35:0] back;
  logic [31:0] rem;
  logic [31:0] quo;

  assign prod_ry = in_r * in_y;
  assign prod_rc = qa * RECIP[term];
  assign back    = estb * term;
  assign rem     = qb - back[31:0];
  assign quo     = (rem >= {28'd0, term}) ? estb + 32'd1 : estb;

  always_ff @(posedge clk) begin
    if (rst) begin
      va        <= 1'b0;
      vb        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      va        <= in_valid;
      vb        <= va;
      out_valid <= vb;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // product r*y in Q.31
      sa <= in_side;
      ya <= in_y;
      qa <= prod_ry[62:31];
      // quotient estimate, at most one short
      sb   <= sa;
      yb   <= ya;
      qb   <= qa;
      estb <= prod_rc[63:32];
      // fix the estimate and add one
      out_side <= sb;
      out_y    <= yb;
      out_r    <= ONE_Q31 + quo;
    end
  end

endmodule
`default_nettype wire

// File: sv/power_law_waveshaper_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// channel   dir  signals                        beat content
// s_        in   s_tvalid s_tready s_tdata      sample_in
// m_        out  m_tvalid m_tready m_tdata      sample_out
// cfg_      in   cfg_write cfg_index cfg_data   one register write
//
// One sample enters each cycle while s_tready is high; a result passes the front
// stages, the log unit, the scale stages, the exp unit and the mix stages before
// it enters the output buffer. The depth is set by the 32 squaring rounds of the
// log unit and the 13 three-stage Horner terms of the exp unit.
// Reset is synchronous: it clears valid bits and loads register defaults.
// A two-entry output buffer holds results; the pipe freezes only when the
// buffer is full and the sink is not ready.
module power_law_waveshaper_unit (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_write,
  input  wire logic [pwsh_pkg::IDX_W-1:0]     cfg_index,
  input  wire logic [pwsh_pkg::CFG_W-1:0]     cfg_data,
  input  wire logic                           s_tvalid,
  output logic                                s_tready,
  // bits up: sample_in
  input  wire logic [pwsh_pkg::DATA_W-1:0]    s_tdata,
  output logic                                m_tvalid,
  input  wire logic                           m_tready,
  // bits up: sample_out
  output logic [pwsh_pkg::DATA_W-1:0]         m_tdata
);
  import pwsh_pkg::*;

  localparam int S = SAMPLE_BITS;
  localparam logic signed [S+20:0] HALF = (S+21)'(32768);
  localparam logic signed [S+4:0]  Y_MAX = (S+5)'((longint'(1) << (S-1)) - 1);
  localparam logic signed [S+4:0]  Y_MIN = -Y_MAX - (S+5)'(1);

  // ---------------- configuration registers ----------------
  logic [15:0] knob, e_low, e_mid, e_high;
  logic [16:0] wet;

  always_ff @(posedge clk) begin
    if (rst) begin
      knob   <= 16'd32768;
      wet    <= 17'd65536;
      e_low  <= 16'd1024;
      e_mid  <= 16'd4096;
      e_high <= 16'd16384;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_KNOB: knob   <= cfg_data[15:0];
        REG_WET:  wet    <= cfg_data;
        REG_LOW:  e_low  <= cfg_data[15:0];
        REG_MID:  e_mid  <= cfg_data[15:0];
        REG_HIGH: e_high <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Exponent pipe: free running from the registers through t_c1, t2_c2, w0_c3 and
  // b_exp; it settles long before a new sample reaches the multiply that uses it.
  logic [16:0] pk;
  logic [16:0] t_c1, t2_c2, wet_c, dry_c;
  logic [15:0] e0_c1, e1_c1, e0_c2, e1_c2;
  logic [33:0] tt;
  logic [32:0] w0_c3, w1_c3;
  logic [33:0] wsum;
  logic [15:0] b_exp;

  assign pk   = 17'd65536 - {1'b0, knob};
  assign tt   = t_c1 * t_c1;
  assign wsum = {1'b0, w0_c3} + {1'b0, w1_c3};

  always_ff @(posedge clk) begin
    if (pk < 17'd32768) begin
      t_c1  <= {pk[15:0], 1'b0};
      e0_c1 <= e_low;
      e1_c1 <= e_mid;
    end else begin
      t_c1  <= (pk - 17'd32768) << 1;
      e0_c1 <= e_mid;
      e1_c1 <= e_high;
    end
    t2_c2 <= tt[32:16];
    e0_c2 <= e0_c1;
    e1_c2 <= e1_c1;
    w0_c3 <= e0_c2 * (17'd65536 - t2_c2);
    w1_c3 <= e1_c2 * t2_c2;
    b_exp <= wsum[31:16];
    wet_c <= (wet > 17'd65536) ? 17'd65536 : wet;
    dry_c <= 17'd65536 - ((wet > 17'd65536) ? 17'd65536 : wet);
  end

  // ---------------- pipe control ----------------
  logic       en;
  logic [1:0] count;
  logic       push, pop;
  logic [S-1:0] buf0, buf1, y_sat;

  assign en       = (count != 2'd2) || m_tready;
  assign s_tready = en;

  // ---------------- front stages ----------------
  side_t sd_in, sd0, sd1, sd2, sd3;
  logic  v0, v1, v2, v3;
  logic [S-1:0] m1, m2;
  logic [4:0]   e2;
  logic [31:0]  z3;

  always_comb begin
    sd_in   = '0;
    sd_in.x = $signed(s_tdata[S-1:0]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sd0 <= sd_in;
      // magnitude; the most negative code maps to one exactly
      sd1 <= {sd0.x, sd0.x[S-1], (sd0.x == '0), sd0.k, sd0.shift};
      m1  <= sd0.x[S-1] ? (~sd0.x + S'(1)) : sd0.x;
      sd2 <= sd1;
      m2  <= m1;
      e2  <= msb_index(m1);
      // normalize to a Q1.31 mantissa
      sd3 <= {sd2.x, sd2.neg, sd2.zero, 5'(S - 1) - e2, sd2.shift};
      z3  <= 32'(m2) << (5'd31 - e2);
    end
  end

  // ---------------- log2 fraction, one bit per stage ----------------
  logic        lv [0:LOG_ROUNDS];
  side_t       ls [0:LOG_ROUNDS];
  logic [31:0] lz [0:LOG_ROUNDS];
  logic [31:0] lf [0:LOG_ROUNDS];

  assign lv[0] = v3;
  assign ls[0] = sd3;
  assign lz[0] = z3;
  assign lf[0] = 32'd0;

  for (genvar i = 0; i < LOG_ROUNDS; i++) begin : g_log
    pwsh_log_step u_log (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (lv[i]),
      .in_side   (ls[i]),
      .in_z      (lz[i]),
      .in_f      (lf[i]),
      .out_valid (lv[i+1]),
      .out_side  (ls[i+1]),
      .out_z     (lz[i+1]),
      .out_f     (lf[i+1])
    );
  end

  // ---------------- scale by the exponent ----------------
  side_t sd4, sd5, sd6, sd7, sd8;
  logic  v4, v5, v6, v7, v8;
  logic [36:0] nl4;
  logic [47:0] plo5;
  logic [20:0] phi5;
  logic [52:0] full;
  logic [40:0] p6;
  logic [31:0] g6;
  logic [9:0]  n7;
  logic [31:0] h7;
  logic [63:0] hprod;
  logic [30:0] y8;

  assign full  = {phi5, 32'd0} + {5'd0, plo5} + 53'd2048;
  assign g6    = p6[31:0];
  assign n7    = {1'b0, p6[40:32]} + {9'd0, (g6 != 32'd0)};
  assign hprod = h7 * LN2_Q32;

  always_ff @(posedge clk) begin
    if (en) begin
      // -log2|x| in Q.32
      sd4 <= ls[LOG_ROUNDS];
      nl4 <= {ls[LOG_ROUNDS].k, 32'd0} - {5'd0, lf[LOG_ROUNDS]};
      // split product to stay within one wide multiplier
      sd5  <= sd4;
      plo5 <= b_exp * nl4[31:0];
      phi5 <= b_exp * nl4[36:32];
      // round to nearest into Q.32
      sd6 <= sd5;
      p6  <= full[52:12];
      // integer and fraction of the negative exponent
      sd7 <= {sd6.x, sd6.neg, sd6.zero, sd6.k, 11'(32 - S) + {1'b0, n7}};
      h7  <= (g6 == 32'd0) ? 32'd0 : (32'd0 - g6);
      // series argument frac*ln2 in Q.31
      sd8 <= sd7;
      y8  <= hprod[63:33];
    end
  end

  // ---------------- 2^frac by Horner series ----------------
  logic        hv [0:TERMS];
  side_t       hs [0:TERMS];
  logic [31:0] hr [0:TERMS];
  logic [30:0] hy [0:TERMS];

  assign hv[0] = v8;
  assign hs[0] = sd8;
  assign hr[0] = ONE_Q31;
  assign hy[0] = y8;

  for (genvar i = 0; i < TERMS; i++) begin : g_exp
    pwsh_exp_step u_exp (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .term      (4'(TERMS - i)),
      .in_valid  (hv[i]),
      .in_side   (hs[i]),
      .in_r      (hr[i]),
      .in_y      (hy[i]),
      .out_valid (hv[i+1]),
      .out_side  (hs[i+1]),
      .out_r     (hr[i+1]),
      .out_y     (hy[i+1])
    );
  end

  // ---------------- output scaling and mix ----------------
  side_t sd9;
  logic  v9, v10;
  logic [32:0] tsh;
  logic [33:0] rnd;
  logic [S:0]  vm9;
  logic signed [S+17:0] dp9, dp10;
  logic signed [S+1:0]  vs;
  logic signed [17:0]   wet_s, dry_s;
  logic signed [S+19:0] wp10;
  logic signed [S+20:0] sum;
  logic signed [S+4:0]  yq;

  // round half up on the shift: ((2r >> s) + 1) >> 1
  assign tsh   = {hr[TERMS], 1'b0} >> hs[TERMS].shift;
  assign rnd   = {1'b0, tsh} + 34'd1;
  assign wet_s = $signed({1'b0, wet_c});
  assign dry_s = $signed({1'b0, dry_c});
  assign vs    = sd9.neg ? -$signed({1'b0, vm9}) : $signed({1'b0, vm9});

  always_ff @(posedge clk) begin
    if (en) begin
      sd9 <= hs[TERMS];
      if (hs[TERMS].zero || (hs[TERMS].shift >= 11'd33)) begin
        vm9 <= '0;
      end else begin
        vm9 <= rnd[S+1:1];
      end
      dp9  <= dry_s * $signed(hs[TERMS].x);
      dp10 <= dp9;
      wp10 <= wet_s * vs;
    end
  end

  // round the mix half up, then clamp to the sample range
  assign sum = wp10 + dp10 + HALF;
  assign yq  = $signed(sum[S+20:16]);

  always_comb begin
    if (yq > Y_MAX) begin
      y_sat = Y_MAX[S-1:0];
    end else if (yq < Y_MIN) begin
      y_sat = Y_MIN[S-1:0];
    end else begin
      y_sat = yq[S-1:0];
    end
  end

  // ---------------- valid bits of the top-level stages ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      v0  <= 1'b0;
      v1  <= 1'b0;
      v2  <= 1'b0;
      v3  <= 1'b0;
      v4  <= 1'b0;
      v5  <= 1'b0;
      v6  <= 1'b0;
      v7  <= 1'b0;
      v8  <= 1'b0;
      v9  <= 1'b0;
      v10 <= 1'b0;
    end else if (en) begin
      v0  <= s_tvalid;
      v1  <= v0;
      v2  <= v1;
      v3  <= v2;
      v4  <= lv[LOG_ROUNDS];
      v5  <= v4;
      v6  <= v5;
      v7  <= v6;
      v8  <= v7;
      v9  <= hv[TERMS];
      v10 <= v9;
    end
  end

  // ---------------- two-entry output buffer ----------------
  assign push     = en && v10;
  assign pop      = m_tvalid && m_tready;
  assign m_tvalid = (count != 2'd0);
  assign m_tdata  = DATA_W'(buf0);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else if (push && !pop) begin
      count <= count + 2'd1;
    end else if (pop && !push) begin
      count <= count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push && pop) begin
      if (count == 2'd1) begin
        buf0 <= y_sat;
      end else begin
        buf0 <= buf1;
        buf1 <= y_sat;
      end
    end else if (push) begin
      if (count == 2'd0) begin
        buf0 <= y_sat;
      end else begin
        buf1 <= y_sat;
      end
    end else if (pop) begin
      buf0 <= buf1;
    end
  end

endmodule
`default_nettype wire
